// ===== src/sgcb_pkg.sv =====
// Package: shared constants, state and step codes, control structs for the gradient blender.
package sgcb_pkg;

    localparam int PHASE_BITS = 12;
    localparam int RATIO_BITS = 16;

    localparam int QBITS     = PHASE_BITS - 2;
    localparam int USHIFT    = 30 - 2 * QBITS;
    localparam int DIV_ITERS = 32 + PHASE_BITS;
    localparam int CNT_W     = $clog2(DIV_ITERS);
    localparam int RATIO_W   = RATIO_BITS + 1;

    localparam logic [31:0] CYCLE_RESET = 32'd1000;
    localparam logic [30:0] ONE_Q30     = 31'd1073741824;
    localparam logic [30:0] SIN_C1      = 31'd1686629713;
    localparam logic [30:0] SIN_C3      = 31'd693598668;
    localparam logic [30:0] SIN_C5      = 31'd85569306;
    localparam logic [30:0] SIN_C7      = 31'd5026995;
    localparam logic [30:0] SIN_C9      = 31'd172272;

    localparam logic [2:0] CFG_START_COLOR = 3'd0;
    localparam logic [2:0] CFG_END_COLOR   = 3'd1;
    localparam logic [2:0] CFG_START_LEVEL = 3'd2;
    localparam logic [2:0] CFG_END_LEVEL   = 3'd3;
    localparam logic [2:0] CFG_CYCLE_MS    = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_USE,
        ST_OUT
    } t_state;

    typedef enum logic [3:0] {
        SP_USQ,
        SP_C9,
        SP_C7,
        SP_C5,
        SP_C3,
        SP_T,
        SP_RED,
        SP_GRN,
        SP_BLU,
        SP_LVL
    } t_step;

    typedef struct packed {
        logic  accept;
        logic  div_step;
        logic  mul_issue;
        logic  mul_use;
        t_step step;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

    function automatic t_step next_step(input t_step s);
        t_step r;
        case (s)
            SP_USQ:  r = SP_C9;
            SP_C9:   r = SP_C7;
            SP_C7:   r = SP_C5;
            SP_C5:   r = SP_C3;
            SP_C3:   r = SP_T;
            SP_T:    r = SP_RED;
            SP_RED:  r = SP_GRN;
            SP_GRN:  r = SP_BLU;
            SP_BLU:  r = SP_LVL;
            default: r = SP_USQ;
        endcase
        return r;
    endfunction

endpackage

// ===== src/sgcb_ctrl.sv =====
// Controller: sequences accept, division, multiply steps and output load.
module sgcb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  sgcb_pkg::t_status i_status,
    output sgcb_pkg::t_cmd   o_cmd
);

    sgcb_pkg::t_state r_state, n_state;
    sgcb_pkg::t_step  r_step, n_step;
    logic [sgcb_pkg::CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sgcb_pkg::ST_IDLE;
            r_step  <= sgcb_pkg::SP_USQ;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_step           = r_step;
        n_cnt            = r_cnt;
        o_in_ready       = 1'b0;
        o_cmd.accept     = 1'b0;
        o_cmd.div_step   = 1'b0;
        o_cmd.mul_issue  = 1'b0;
        o_cmd.mul_use    = 1'b0;
        o_cmd.step       = r_step;
        o_cmd.out_load   = 1'b0;
        case (r_state)
            sgcb_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_cnt        = '0;
                    n_state      = sgcb_pkg::ST_DIV;
                end
            end
            sgcb_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == sgcb_pkg::CNT_W'(sgcb_pkg::DIV_ITERS - 1)) begin
                    n_step  = sgcb_pkg::SP_USQ;
                    n_state = sgcb_pkg::ST_MUL;
                end
            end
            sgcb_pkg::ST_MUL: begin
                o_cmd.mul_issue = 1'b1;
                n_state         = sgcb_pkg::ST_USE;
            end
            sgcb_pkg::ST_USE: begin
                o_cmd.mul_use = 1'b1;
                if (r_step == sgcb_pkg::SP_LVL) begin
                    n_state = sgcb_pkg::ST_OUT;
                end else begin
                    n_step  = sgcb_pkg::next_step(r_step);
                    n_state = sgcb_pkg::ST_MUL;
                end
            end
            sgcb_pkg::ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = sgcb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sgcb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/sgcb_datapath.sv =====
// Datapath: config registers, elapsed counter, restoring divider, shared multiplier, output register.
module sgcb_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    input  logic [7:0]        i_advance_ms,
    input  sgcb_pkg::t_cmd    i_cmd,
    output sgcb_pkg::t_status o_status,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [31:0]       o_out_data
);

    localparam int PB = sgcb_pkg::PHASE_BITS;
    localparam int Q  = sgcb_pkg::QBITS;
    localparam int RB = sgcb_pkg::RATIO_BITS;
    localparam int RW = sgcb_pkg::RATIO_W;

    logic [23:0] r_start_color, r_end_color;
    logic [7:0]  r_start_level, r_end_level;
    logic [31:0] r_cycle_ms;
    logic [31:0] r_elapsed;

    logic [31+PB:0] r_dvd;
    logic [31:0]    r_rem;
    logic [PB-1:0]  r_p;

    logic [63:0]    r_prod;
    logic [30:0]    r_u, r_acc;
    logic [RW-1:0]  r_ratio;
    logic [7:0]     r_red, r_grn, r_blu, r_lvl;

    logic [31:0]    r_m_data;
    logic           r_m_valid;

    logic [31:0]    n_elapsed;
    logic [31:0]    cyc;
    logic [32:0]    trial;
    logic           q_bit;

    logic [1:0]     quad;
    logic [Q:0]     frac;
    logic [30:0]    t_q30;

    logic [31:0]    mul_a, mul_b;
    logic [7:0]     ch_a, ch_b, ch_mag;
    logic           ch_up;
    logic [33:0]    prod_hi;
    logic [30:0]    sine;
    logic [31:0]    twice;
    logic [63:0]    usq_shift;
    logic [63:0]    dn_sum;
    logic [7:0]     ch_res;

    assign n_elapsed = r_elapsed + {24'd0, i_advance_ms};
    assign cyc       = (r_cycle_ms == 32'd0) ? 32'd1 : r_cycle_ms;
    assign trial     = {r_rem, r_dvd[31+PB]};
    assign q_bit     = (trial >= {1'b0, cyc});

    assign quad  = r_p[PB-1:PB-2];
    assign frac  = quad[0] ? ((Q+1)'(1) << Q) - {1'b0, r_p[Q-1:0]} : {1'b0, r_p[Q-1:0]};
    assign t_q30 = 31'(frac) << (30 - Q);

    always_comb begin
        case (i_cmd.step)
            sgcb_pkg::SP_RED: begin
                ch_a = r_start_color[23:16];
                ch_b = r_end_color[23:16];
            end
            sgcb_pkg::SP_GRN: begin
                ch_a = r_start_color[15:8];
                ch_b = r_end_color[15:8];
            end
            sgcb_pkg::SP_BLU: begin
                ch_a = r_start_color[7:0];
                ch_b = r_end_color[7:0];
            end
            default: begin
                ch_a = r_start_level;
                ch_b = r_end_level;
            end
        endcase
    end

    assign ch_up  = (ch_b >= ch_a);
    assign ch_mag = ch_up ? (ch_b - ch_a) : (ch_a - ch_b);

    always_comb begin
        case (i_cmd.step)
            sgcb_pkg::SP_USQ: begin
                mul_a = 32'(frac);
                mul_b = 32'(frac);
            end
            sgcb_pkg::SP_C9: begin
                mul_a = {1'b0, r_u};
                mul_b = {1'b0, sgcb_pkg::SIN_C9};
            end
            sgcb_pkg::SP_C7, sgcb_pkg::SP_C5, sgcb_pkg::SP_C3: begin
                mul_a = {1'b0, r_u};
                mul_b = {1'b0, r_acc};
            end
            sgcb_pkg::SP_T: begin
                mul_a = {1'b0, t_q30};
                mul_b = {1'b0, r_acc};
            end
            default: begin
                mul_a = {24'd0, ch_mag};
                mul_b = 32'(r_ratio);
            end
        endcase
    end

    assign prod_hi   = r_prod[63:30];
    assign sine      = (prod_hi > {3'd0, sgcb_pkg::ONE_Q30}) ? sgcb_pkg::ONE_Q30 : prod_hi[30:0];
    assign twice     = quad[1] ? ({1'b0, sgcb_pkg::ONE_Q30} - {1'b0, sine})
                               : ({1'b0, sgcb_pkg::ONE_Q30} + {1'b0, sine});
    assign usq_shift = r_prod << sgcb_pkg::USHIFT;
    assign dn_sum    = r_prod + 64'((64'd1 << RB) - 64'd1);
    assign ch_res    = ch_up ? (ch_a + r_prod[RB+7:RB]) : (ch_a - dn_sum[RB+7:RB]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_color <= '0;
            r_end_color   <= '0;
            r_start_level <= '0;
            r_end_level   <= '0;
            r_cycle_ms    <= sgcb_pkg::CYCLE_RESET;
            r_elapsed     <= '0;
            r_m_valid     <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_elapsed <= n_elapsed;
            end else if (i_cfg_we) begin
                case (i_cfg_idx)
                    sgcb_pkg::CFG_START_COLOR: begin
                        r_start_color <= i_cfg_data[23:0];
                        r_elapsed     <= '0;
                    end
                    sgcb_pkg::CFG_END_COLOR: begin
                        r_end_color <= i_cfg_data[23:0];
                        r_elapsed   <= '0;
                    end
                    sgcb_pkg::CFG_START_LEVEL: begin
                        r_start_level <= i_cfg_data[7:0];
                        r_elapsed     <= '0;
                    end
                    sgcb_pkg::CFG_END_LEVEL: begin
                        r_end_level <= i_cfg_data[7:0];
                        r_elapsed   <= '0;
                    end
                    sgcb_pkg::CFG_CYCLE_MS: begin
                        r_cycle_ms <= i_cfg_data;
                        r_elapsed  <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_dvd <= {n_elapsed, PB'(0)};
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[30+PB:0], 1'b0};
            r_rem <= q_bit ? 32'(trial - {1'b0, cyc}) : trial[31:0];
            r_p   <= {r_p[PB-2:0], q_bit};
        end
        if (i_cmd.mul_issue) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.mul_use) begin
            case (i_cmd.step)
                sgcb_pkg::SP_USQ: r_u     <= usq_shift[30:0];
                sgcb_pkg::SP_C9:  r_acc   <= 31'({3'd0, sgcb_pkg::SIN_C7} - prod_hi);
                sgcb_pkg::SP_C7:  r_acc   <= 31'({3'd0, sgcb_pkg::SIN_C5} - prod_hi);
                sgcb_pkg::SP_C5:  r_acc   <= 31'({3'd0, sgcb_pkg::SIN_C3} - prod_hi);
                sgcb_pkg::SP_C3:  r_acc   <= 31'({3'd0, sgcb_pkg::SIN_C1} - prod_hi);
                sgcb_pkg::SP_T:   r_ratio <= twice[31:31-RB];
                sgcb_pkg::SP_RED: r_red   <= ch_res;
                sgcb_pkg::SP_GRN: r_grn   <= ch_res;
                sgcb_pkg::SP_BLU: r_blu   <= ch_res;
                default:          r_lvl   <= ch_res;
            endcase
        end
        if (i_cmd.out_load) begin
            r_m_data <= {r_lvl, r_blu, r_grn, r_red};
        end
    end

    assign o_status.out_free = !r_m_valid || i_out_ready;
    assign o_out_valid       = r_m_valid;
    assign o_out_data        = r_m_data;

endmodule

// ===== src/sine_gradient_color_blend.sv =====
// Top level: sine-shaped color and brightness gradient generator.
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid / s_tready  s_tdata[7:0]  advance_ms
//  m_       out  m_tvalid / m_tready  m_tdata[31:0] red, green, blue, level
//  cfg      in   i_cfg_we             i_cfg_idx, i_cfg_data
//
// One transaction runs through an accept, 32 + PHASE_BITS restoring divider
// steps, ten steps on the shared 32x32 multiplier (each an issue state, then
// a use state) and one output load. A finished result waits in the output
// register while the next transaction is taken; the load stalls only while a
// previous result is still held. Reset is synchronous and clears the control
// state, the config registers (cycle_ms to 1000), the elapsed time and the
// output valid flag. A config write to index 0 to 4 clears the elapsed time.
module sine_gradient_color_blend (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] advance_ms
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue, [31:24] level
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    sgcb_pkg::t_cmd    cmd;
    sgcb_pkg::t_status status;

    sgcb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sgcb_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_advance_ms (s_tdata),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_out_valid  (m_tvalid),
        .i_out_ready  (m_tready),
        .o_out_data   (m_tdata)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready stayed high after a transaction was taken");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> status.out_free)
        else $error("output loaded over an untaken result");

    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_step |-> !s_tready && !cmd.mul_issue && !cmd.out_load)
        else $error("divider step overlaps another command");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> m_tvalid)
        else $error("result not presented after load");

endmodule
